// ===== src/c65_pkg.sv =====
// shared types, codes and the opcode decode table of the 6502 core
package c65_pkg;

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_DONE  = 2'd2,
        K_BAD   = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY, OP_BIT, OP_LDA,
        OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC,
        OP_DEC, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED, OP_TAX, OP_TXA,
        OP_TAY, OP_TYA, OP_TSX, OP_TXS, OP_INX, OP_DEX, OP_INY, OP_DEY, OP_NOP, OP_BRK,
        OP_JSR, OP_RTI, OP_RTS, OP_JMP, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_BR
    } op_t;

    typedef enum logic [3:0] {
        M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IND, M_IZX, M_IZY, M_REL
    } mode_t;

    localparam logic [15:0] VEC_RESET = 16'hfffc;
    localparam logic [15:0] VEC_NMI   = 16'hfffa;
    localparam logic [15:0] VEC_IRQ   = 16'hfffe;
    localparam logic [7:0]  STACK_HI  = 8'h01;
    localparam logic [7:0]  FL_UNUSED = 8'h20;
    localparam logic [7:0]  FL_PUSHB  = 8'h30;
    localparam logic [7:0]  SP_INIT   = 8'hff;
    localparam int          MAX_RES   = 4;

    typedef struct packed {
        logic       operation;
        logic [7:0] read_data;
        logic       reset_line;
        logic       irq_line;
        logic       nmi_request;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        last;
        logic [15:0] prog_counter;
        logic [7:0]  accumulator;
        logic [7:0]  index_x_out;
        logic [7:0]  index_y_out;
        logic [7:0]  stack_pointer;
        logic [7:0]  status_flags;
        logic [63:0] cycle_count;
    } result_t;

    typedef struct packed {
        logic [2:0]              count;
        result_t [MAX_RES-1:0]   res;
    } bundle_t;

    typedef struct packed {
        logic       ok;
        op_t        op;
        mode_t      mode;
        logic [2:0] cyc;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] c);
        dec_t d;
        d = '{1'b0, OP_NOP, M_IMP, 3'd0};
        case (c)
            8'h00: d = '{1'b1, OP_BRK, M_IMP, 3'd7};
            8'h01: d = '{1'b1, OP_ORA, M_IZX, 3'd6};
            8'h05: d = '{1'b1, OP_ORA, M_ZP,  3'd3};
            8'h06: d = '{1'b1, OP_ASL, M_ZP,  3'd5};
            8'h08: d = '{1'b1, OP_PHP, M_IMP, 3'd3};
            8'h09: d = '{1'b1, OP_ORA, M_IMM, 3'd2};
            8'h0a: d = '{1'b1, OP_ASL, M_IMP, 3'd2};
            8'h0d: d = '{1'b1, OP_ORA, M_ABS, 3'd4};
            8'h0e: d = '{1'b1, OP_ASL, M_ABS, 3'd6};
            8'h10: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'h11: d = '{1'b1, OP_ORA, M_IZY, 3'd5};
            8'h15: d = '{1'b1, OP_ORA, M_ZPX, 3'd4};
            8'h16: d = '{1'b1, OP_ASL, M_ZPX, 3'd6};
            8'h18: d = '{1'b1, OP_CLC, M_IMP, 3'd2};
            8'h19: d = '{1'b1, OP_ORA, M_ABY, 3'd4};
            8'h1d: d = '{1'b1, OP_ORA, M_ABX, 3'd4};
            8'h1e: d = '{1'b1, OP_ASL, M_ABX, 3'd7};
            8'h20: d = '{1'b1, OP_JSR, M_ABS, 3'd6};
            8'h21: d = '{1'b1, OP_AND, M_IZX, 3'd6};
            8'h24: d = '{1'b1, OP_BIT, M_ZP,  3'd3};
            8'h25: d = '{1'b1, OP_AND, M_ZP,  3'd3};
            8'h26: d = '{1'b1, OP_ROL, M_ZP,  3'd5};
            8'h28: d = '{1'b1, OP_PLP, M_IMP, 3'd4};
            8'h29: d = '{1'b1, OP_AND, M_IMM, 3'd2};
            8'h2a: d = '{1'b1, OP_ROL, M_IMP, 3'd2};
            8'h2c: d = '{1'b1, OP_BIT, M_ABS, 3'd4};
            8'h2d: d = '{1'b1, OP_AND, M_ABS, 3'd4};
            8'h2e: d = '{1'b1, OP_ROL, M_ABS, 3'd6};
            8'h30: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'h31: d = '{1'b1, OP_AND, M_IZY, 3'd5};
            8'h35: d = '{1'b1, OP_AND, M_ZPX, 3'd4};
            8'h36: d = '{1'b1, OP_ROL, M_ZPX, 3'd6};
            8'h38: d = '{1'b1, OP_SEC, M_IMP, 3'd2};
            8'h39: d = '{1'b1, OP_AND, M_ABY, 3'd4};
            8'h3d: d = '{1'b1, OP_AND, M_ABX, 3'd4};
            8'h3e: d = '{1'b1, OP_ROL, M_ABX, 3'd7};
            8'h40: d = '{1'b1, OP_RTI, M_IMP, 3'd6};
            8'h41: d = '{1'b1, OP_EOR, M_IZX, 3'd6};
            8'h45: d = '{1'b1, OP_EOR, M_ZP,  3'd3};
            8'h46: d = '{1'b1, OP_LSR, M_ZP,  3'd5};
            8'h48: d = '{1'b1, OP_PHA, M_IMP, 3'd3};
            8'h49: d = '{1'b1, OP_EOR, M_IMM, 3'd2};
            8'h4a: d = '{1'b1, OP_LSR, M_IMP, 3'd2};
            8'h4c: d = '{1'b1, OP_JMP, M_ABS, 3'd3};
            8'h4d: d = '{1'b1, OP_EOR, M_ABS, 3'd4};
            8'h4e: d = '{1'b1, OP_LSR, M_ABS, 3'd6};
            8'h50: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'h51: d = '{1'b1, OP_EOR, M_IZY, 3'd5};
            8'h55: d = '{1'b1, OP_EOR, M_ZPX, 3'd4};
            8'h56: d = '{1'b1, OP_LSR, M_ZPX, 3'd6};
            8'h58: d = '{1'b1, OP_CLI, M_IMP, 3'd2};
            8'h59: d = '{1'b1, OP_EOR, M_ABY, 3'd4};
            8'h5d: d = '{1'b1, OP_EOR, M_ABX, 3'd4};
            8'h5e: d = '{1'b1, OP_LSR, M_ABX, 3'd7};
            8'h60: d = '{1'b1, OP_RTS, M_IMP, 3'd6};
            8'h61: d = '{1'b1, OP_ADC, M_IZX, 3'd6};
            8'h65: d = '{1'b1, OP_ADC, M_ZP,  3'd3};
            8'h66: d = '{1'b1, OP_ROR, M_ZP,  3'd5};
            8'h68: d = '{1'b1, OP_PLA, M_IMP, 3'd4};
            8'h69: d = '{1'b1, OP_ADC, M_IMM, 3'd2};
            8'h6a: d = '{1'b1, OP_ROR, M_IMP, 3'd2};
            8'h6c: d = '{1'b1, OP_JMP, M_IND, 3'd5};
            8'h6d: d = '{1'b1, OP_ADC, M_ABS, 3'd4};
            8'h6e: d = '{1'b1, OP_ROR, M_ABS, 3'd6};
            8'h70: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'h71: d = '{1'b1, OP_ADC, M_IZY, 3'd5};
            8'h75: d = '{1'b1, OP_ADC, M_ZPX, 3'd4};
            8'h76: d = '{1'b1, OP_ROR, M_ZPX, 3'd6};
            8'h78: d = '{1'b1, OP_SEI, M_IMP, 3'd2};
            8'h79: d = '{1'b1, OP_ADC, M_ABY, 3'd4};
            8'h7d: d = '{1'b1, OP_ADC, M_ABX, 3'd4};
            8'h7e: d = '{1'b1, OP_ROR, M_ABX, 3'd7};
            8'h81: d = '{1'b1, OP_STA, M_IZX, 3'd6};
            8'h84: d = '{1'b1, OP_STY, M_ZP,  3'd3};
            8'h85: d = '{1'b1, OP_STA, M_ZP,  3'd3};
            8'h86: d = '{1'b1, OP_STX, M_ZP,  3'd3};
            8'h88: d = '{1'b1, OP_DEY, M_IMP, 3'd2};
            8'h8a: d = '{1'b1, OP_TXA, M_IMP, 3'd2};
            8'h8c: d = '{1'b1, OP_STY, M_ABS, 3'd4};
            8'h8d: d = '{1'b1, OP_STA, M_ABS, 3'd4};
            8'h8e: d = '{1'b1, OP_STX, M_ABS, 3'd4};
            8'h90: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'h91: d = '{1'b1, OP_STA, M_IZY, 3'd6};
            8'h94: d = '{1'b1, OP_STY, M_ZPX, 3'd4};
            8'h95: d = '{1'b1, OP_STA, M_ZPX, 3'd4};
            8'h96: d = '{1'b1, OP_STX, M_ZPY, 3'd4};
            8'h98: d = '{1'b1, OP_TYA, M_IMP, 3'd2};
            8'h99: d = '{1'b1, OP_STA, M_ABY, 3'd5};
            8'h9a: d = '{1'b1, OP_TXS, M_IMP, 3'd2};
            8'h9d: d = '{1'b1, OP_STA, M_ABX, 3'd5};
            8'ha0: d = '{1'b1, OP_LDY, M_IMM, 3'd2};
            8'ha1: d = '{1'b1, OP_LDA, M_IZX, 3'd6};
            8'ha2: d = '{1'b1, OP_LDX, M_IMM, 3'd2};
            8'ha4: d = '{1'b1, OP_LDY, M_ZP,  3'd3};
            8'ha5: d = '{1'b1, OP_LDA, M_ZP,  3'd3};
            8'ha6: d = '{1'b1, OP_LDX, M_ZP,  3'd3};
            8'ha8: d = '{1'b1, OP_TAY, M_IMP, 3'd2};
            8'ha9: d = '{1'b1, OP_LDA, M_IMM, 3'd2};
            8'haa: d = '{1'b1, OP_TAX, M_IMP, 3'd2};
            8'hac: d = '{1'b1, OP_LDY, M_ABS, 3'd4};
            8'had: d = '{1'b1, OP_LDA, M_ABS, 3'd4};
            8'hae: d = '{1'b1, OP_LDX, M_ABS, 3'd4};
            8'hb0: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'hb1: d = '{1'b1, OP_LDA, M_IZY, 3'd5};
            8'hb4: d = '{1'b1, OP_LDY, M_ZPX, 3'd4};
            8'hb5: d = '{1'b1, OP_LDA, M_ZPX, 3'd4};
            8'hb6: d = '{1'b1, OP_LDX, M_ZPY, 3'd4};
            8'hb8: d = '{1'b1, OP_CLV, M_IMP, 3'd2};
            8'hb9: d = '{1'b1, OP_LDA, M_ABY, 3'd4};
            8'hba: d = '{1'b1, OP_TSX, M_IMP, 3'd2};
            8'hbc: d = '{1'b1, OP_LDY, M_ABX, 3'd4};
            8'hbd: d = '{1'b1, OP_LDA, M_ABX, 3'd4};
            8'hbe: d = '{1'b1, OP_LDX, M_ABY, 3'd4};
            8'hc0: d = '{1'b1, OP_CPY, M_IMM, 3'd2};
            8'hc1: d = '{1'b1, OP_CMP, M_IZX, 3'd6};
            8'hc4: d = '{1'b1, OP_CPY, M_ZP,  3'd3};
            8'hc5: d = '{1'b1, OP_CMP, M_ZP,  3'd3};
            8'hc6: d = '{1'b1, OP_DEC, M_ZP,  3'd5};
            8'hc8: d = '{1'b1, OP_INY, M_IMP, 3'd2};
            8'hc9: d = '{1'b1, OP_CMP, M_IMM, 3'd2};
            8'hca: d = '{1'b1, OP_DEX, M_IMP, 3'd2};
            8'hcc: d = '{1'b1, OP_CPY, M_ABS, 3'd4};
            8'hcd: d = '{1'b1, OP_CMP, M_ABS, 3'd4};
            8'hce: d = '{1'b1, OP_DEC, M_ABS, 3'd6};
            8'hd0: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'hd1: d = '{1'b1, OP_CMP, M_IZY, 3'd5};
            8'hd5: d = '{1'b1, OP_CMP, M_ZPX, 3'd4};
            8'hd6: d = '{1'b1, OP_DEC, M_ZPX, 3'd6};
            8'hd8: d = '{1'b1, OP_CLD, M_IMP, 3'd2};
            8'hd9: d = '{1'b1, OP_CMP, M_ABY, 3'd4};
            8'hdd: d = '{1'b1, OP_CMP, M_ABX, 3'd4};
            8'hde: d = '{1'b1, OP_DEC, M_ABX, 3'd7};
            8'he0: d = '{1'b1, OP_CPX, M_IMM, 3'd2};
            8'he1: d = '{1'b1, OP_SBC, M_IZX, 3'd6};
            8'he4: d = '{1'b1, OP_CPX, M_ZP,  3'd3};
            8'he5: d = '{1'b1, OP_SBC, M_ZP,  3'd3};
            8'he6: d = '{1'b1, OP_INC, M_ZP,  3'd5};
            8'he8: d = '{1'b1, OP_INX, M_IMP, 3'd2};
            8'he9: d = '{1'b1, OP_SBC, M_IMM, 3'd2};
            8'hea: d = '{1'b1, OP_NOP, M_IMP, 3'd2};
            8'hec: d = '{1'b1, OP_CPX, M_ABS, 3'd4};
            8'hed: d = '{1'b1, OP_SBC, M_ABS, 3'd4};
            8'hee: d = '{1'b1, OP_INC, M_ABS, 3'd6};
            8'hf0: d = '{1'b1, OP_BR,  M_REL, 3'd2};
            8'hf1: d = '{1'b1, OP_SBC, M_IZY, 3'd5};
            8'hf5: d = '{1'b1, OP_SBC, M_ZPX, 3'd4};
            8'hf6: d = '{1'b1, OP_INC, M_ZPX, 3'd6};
            8'hf8: d = '{1'b1, OP_SED, M_IMP, 3'd2};
            8'hf9: d = '{1'b1, OP_SBC, M_ABY, 3'd4};
            8'hfd: d = '{1'b1, OP_SBC, M_ABX, 3'd4};
            8'hfe: d = '{1'b1, OP_INC, M_ABX, 3'd7};
            default: d = '{1'b0, OP_NOP, M_IMP, 3'd0};
        endcase
        return d;
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [15:0] a,
                                       input logic [7:0] wd);
        result_t r;
        r = '0;
        r.kind = k;
        r.bus_address = a;
        r.write_data = wd;
        return r;
    endfunction

endpackage

// ===== src/c65_step.sv =====
// cpu state registers and the per-item step logic that builds a result bundle
module c65_step
    import c65_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    output bundle_t bundle
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_VEC_LO, PH_VEC_HI, PH_OPCODE, PH_OPER_LO, PH_OPER_HI,
        PH_PTR_LO, PH_PTR_HI, PH_DATA, PH_STK1, PH_STK2, PH_STK3
    } phase_t;

    localparam logic [7:0] FL_C = 8'h01;
    localparam logic [7:0] FL_I = 8'h04;
    localparam logic [7:0] FL_D = 8'h08;
    localparam logic [7:0] FL_V = 8'h40;

    phase_t      ph_reg, ph_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] oa_reg, oa_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  sp_reg, sp_next;
    logic [7:0]  p_reg, p_next;
    logic [63:0] cyc_reg, cyc_next;
    logic        nmi_reg, nmi_next;
    op_t         op_reg, op_next;
    mode_t       md_reg, md_next;
    logic [2:0]  dc_reg, dc_next;

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] f;
        f = p;
        f[7] = v[7];
        f[1] = (v == 8'h00);
        return f;
    endfunction

    function automatic logic [15:0] modify(input op_t op, input logic [7:0] p,
                                           input logic [7:0] m);
        logic [7:0] r;
        logic [7:0] f;
        f = p;
        case (op)
            OP_ASL: begin f[0] = m[7]; r = {m[6:0], 1'b0}; end
            OP_LSR: begin f[0] = m[0]; r = {1'b0, m[7:1]}; end
            OP_ROL: begin f[0] = m[7]; r = {m[6:0], p[0]}; end
            OP_ROR: begin f[0] = m[0]; r = {p[0], m[7:1]}; end
            OP_INC: r = m + 8'd1;
            default: r = m - 8'd1;
        endcase
        return {nz(f, r), r};
    endfunction

    function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
                                             input logic [7:0] m);
        logic [7:0] f;
        logic [7:0] diff;
        f = p;
        diff = r - m;
        f[7] = diff[7];
        f[0] = (r >= m);
        f[1] = (r == m);
        return f;
    endfunction

    always_comb
    begin : step_logic
        dec_t        dec;
        logic [7:0]  d;
        logic [8:0]  tot;
        logic [7:0]  m;
        logic [8:0]  lo9;
        logic [15:0] ea;
        logic [15:0] tgt;
        logic [15:0] mr;
        logic        do_oper;
        logic        fin;
        logic        brk_cond;
        logic [7:0]  stv;

        ph_next  = ph_reg;
        pc_next  = pc_reg;
        oa_next  = oa_reg;
        a_next   = a_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        p_next   = p_reg;
        cyc_next = cyc_reg;
        nmi_next = nmi_reg;
        op_next  = op_reg;
        md_next  = md_reg;
        dc_next  = dc_reg;
        bundle   = '0;
        d        = item.read_data;
        dec      = decode(d);
        tot      = '0;
        m        = '0;
        lo9      = '0;
        ea       = '0;
        tgt      = '0;
        mr       = '0;
        do_oper  = 1'b0;
        fin      = 1'b0;
        brk_cond = 1'b0;
        stv      = '0;

        if (!item.operation)
        begin
            if (item.nmi_request)
                nmi_next = 1'b1;
            if (item.reset_line)
            begin
                cyc_next = '0;
                p_next = FL_UNUSED;
                sp_next = SP_INIT;
                oa_next = VEC_RESET;
                bundle.res[bundle.count[1:0]] = mk_res(K_READ, VEC_RESET, 8'h00);
                bundle.count = bundle.count + 3'd1;
                ph_next = PH_VEC_LO;
            end
            else if (nmi_next || (!p_reg[2] && item.irq_line))
            begin
                bundle.res[0] = mk_res(K_WRITE, {STACK_HI, sp_next}, pc_reg[15:8]);
                bundle.res[1] = mk_res(K_WRITE, {STACK_HI, sp_next - 8'd1}, pc_reg[7:0]);
                bundle.res[2] = mk_res(K_WRITE, {STACK_HI, sp_next - 8'd2},
                                       p_reg | FL_UNUSED);
                sp_next = sp_next - 8'd3;
                cyc_next = cyc_next + 64'd7;
                if (nmi_next)
                begin
                    nmi_next = 1'b0;
                    oa_next = VEC_NMI;
                end
                else
                begin
                    p_next = p_next | FL_I;
                    oa_next = VEC_IRQ;
                end
                bundle.res[3] = mk_res(K_READ, oa_next, 8'h00);
                bundle.count = 3'd4;
                ph_next = PH_VEC_LO;
            end
            else
            begin
                bundle.res[0] = mk_res(K_READ, pc_reg, 8'h00);
                bundle.count = 3'd1;
                pc_next = pc_reg + 16'd1;
                ph_next = PH_OPCODE;
            end
        end
        else
        begin
            case (ph_reg)
                PH_VEC_LO:
                begin
                    bundle.res[0] = mk_res(K_READ, oa_reg + 16'd1, 8'h00);
                    bundle.count = 3'd1;
                    oa_next = {8'h00, d};
                    ph_next = PH_VEC_HI;
                end
                PH_VEC_HI:
                begin
                    pc_next = {d, oa_reg[7:0]};
                    fin = 1'b1;
                end
                PH_OPCODE:
                begin
                    if (!dec.ok)
                    begin
                        bundle.res[0] = mk_res(K_BAD, pc_reg - 16'd1, 8'h00);
                        bundle.count = 3'd1;
                        ph_next = PH_IDLE;
                    end
                    else
                    begin
                        op_next = dec.op;
                        md_next = dec.mode;
                        dc_next = dec.cyc;
                        cyc_next = cyc_reg + {61'd0, dec.cyc};
                        case (dec.mode)
                            M_IMP:
                            begin
                                case (dec.op)
                                    OP_BRK:
                                    begin
                                        tgt = pc_reg + 16'd1;
                                        pc_next = tgt;
                                        bundle.res[0] = mk_res(K_WRITE, {STACK_HI, sp_reg},
                                                               tgt[15:8]);
                                        bundle.res[1] = mk_res(K_WRITE,
                                                               {STACK_HI, sp_reg - 8'd1},
                                                               tgt[7:0]);
                                        bundle.res[2] = mk_res(K_WRITE,
                                                               {STACK_HI, sp_reg - 8'd2},
                                                               p_reg | FL_PUSHB);
                                        bundle.res[3] = mk_res(K_READ, VEC_IRQ, 8'h00);
                                        bundle.count = 3'd4;
                                        sp_next = sp_reg - 8'd3;
                                        p_next = p_reg | FL_I;
                                        oa_next = VEC_IRQ;
                                        ph_next = PH_VEC_LO;
                                    end
                                    OP_PHA, OP_PHP:
                                    begin
                                        stv = (dec.op == OP_PHA) ? a_reg : (p_reg | FL_PUSHB);
                                        bundle.res[0] = mk_res(K_WRITE, {STACK_HI, sp_reg},
                                                               stv);
                                        bundle.count = 3'd1;
                                        sp_next = sp_reg - 8'd1;
                                        fin = 1'b1;
                                    end
                                    OP_PLA, OP_PLP, OP_RTI, OP_RTS:
                                    begin
                                        sp_next = sp_reg + 8'd1;
                                        bundle.res[0] = mk_res(K_READ, {STACK_HI, sp_next},
                                                               8'h00);
                                        bundle.count = 3'd1;
                                        ph_next = PH_STK1;
                                    end
                                    OP_CLC: begin p_next = p_reg & ~FL_C; fin = 1'b1; end
                                    OP_SEC: begin p_next = p_reg | FL_C; fin = 1'b1; end
                                    OP_CLI: begin p_next = p_reg & ~FL_I; fin = 1'b1; end
                                    OP_SEI: begin p_next = p_reg | FL_I; fin = 1'b1; end
                                    OP_CLV: begin p_next = p_reg & ~FL_V; fin = 1'b1; end
                                    OP_CLD: begin p_next = p_reg & ~FL_D; fin = 1'b1; end
                                    OP_SED: begin p_next = p_reg | FL_D; fin = 1'b1; end
                                    OP_TAX:
                                    begin
                                        x_next = a_reg; p_next = nz(p_reg, a_reg); fin = 1'b1;
                                    end
                                    OP_TXA:
                                    begin
                                        a_next = x_reg; p_next = nz(p_reg, x_reg); fin = 1'b1;
                                    end
                                    OP_TAY:
                                    begin
                                        y_next = a_reg; p_next = nz(p_reg, a_reg); fin = 1'b1;
                                    end
                                    OP_TYA:
                                    begin
                                        a_next = y_reg; p_next = nz(p_reg, y_reg); fin = 1'b1;
                                    end
                                    OP_TSX:
                                    begin
                                        x_next = sp_reg; p_next = nz(p_reg, sp_reg);
                                        fin = 1'b1;
                                    end
                                    OP_TXS: begin sp_next = x_reg; fin = 1'b1; end
                                    OP_INX, OP_DEX:
                                    begin
                                        x_next = (dec.op == OP_INX) ? x_reg + 8'd1
                                                                    : x_reg - 8'd1;
                                        p_next = nz(p_reg, x_next);
                                        fin = 1'b1;
                                    end
                                    OP_INY, OP_DEY:
                                    begin
                                        y_next = (dec.op == OP_INY) ? y_reg + 8'd1
                                                                    : y_reg - 8'd1;
                                        p_next = nz(p_reg, y_next);
                                        fin = 1'b1;
                                    end
                                    OP_ASL, OP_LSR, OP_ROL, OP_ROR:
                                    begin
                                        mr = modify(dec.op, p_reg, a_reg);
                                        p_next = mr[15:8];
                                        a_next = mr[7:0];
                                        fin = 1'b1;
                                    end
                                    default: fin = 1'b1;
                                endcase
                            end
                            M_IMM:
                            begin
                                oa_next = pc_reg;
                                bundle.res[0] = mk_res(K_READ, pc_reg, 8'h00);
                                bundle.count = 3'd1;
                                pc_next = pc_reg + 16'd1;
                                ph_next = PH_DATA;
                            end
                            M_REL:
                            begin
                                case (d[7:6])
                                    2'd0: brk_cond = p_reg[7];
                                    2'd1: brk_cond = p_reg[6];
                                    2'd2: brk_cond = p_reg[0];
                                    default: brk_cond = p_reg[1];
                                endcase
                                pc_next = pc_reg + 16'd1;
                                if (brk_cond != d[5])
                                    fin = 1'b1;
                                else
                                begin
                                    bundle.res[0] = mk_res(K_READ, pc_reg, 8'h00);
                                    bundle.count = 3'd1;
                                    ph_next = PH_OPER_LO;
                                end
                            end
                            default:
                            begin
                                bundle.res[0] = mk_res(K_READ, pc_reg, 8'h00);
                                bundle.count = 3'd1;
                                pc_next = pc_reg + 16'd1;
                                ph_next = PH_OPER_LO;
                            end
                        endcase
                    end
                end
                PH_OPER_LO:
                begin
                    case (md_reg)
                        M_ZP:  begin do_oper = 1'b1; ea = {8'h00, d}; end
                        M_ZPX: begin do_oper = 1'b1; ea = {8'h00, d + x_reg}; end
                        M_ZPY: begin do_oper = 1'b1; ea = {8'h00, d + y_reg}; end
                        M_IZX, M_IZY:
                        begin
                            oa_next = {8'h00, (md_reg == M_IZX) ? d + x_reg : d};
                            bundle.res[0] = mk_res(K_READ, oa_next, 8'h00);
                            bundle.count = 3'd1;
                            ph_next = PH_PTR_LO;
                        end
                        M_REL:
                        begin
                            tgt = pc_reg + {{8{d[7]}}, d};
                            cyc_next = cyc_reg + ((tgt[15:8] != pc_reg[15:8]) ? 64'd2
                                                                                : 64'd1);
                            pc_next = tgt;
                            fin = 1'b1;
                        end
                        default:
                        begin
                            oa_next = {8'h00, d};
                            bundle.res[0] = mk_res(K_READ, pc_reg, 8'h00);
                            bundle.count = 3'd1;
                            pc_next = pc_reg + 16'd1;
                            ph_next = PH_OPER_HI;
                        end
                    endcase
                end
                PH_OPER_HI:
                begin
                    ea = {d, oa_reg[7:0]};
                    case (md_reg)
                        M_ABS:
                        begin
                            if (op_reg == OP_JMP)
                            begin
                                pc_next = ea;
                                fin = 1'b1;
                            end
                            else if (op_reg == OP_JSR)
                            begin
                                tgt = pc_reg - 16'd1;
                                bundle.res[0] = mk_res(K_WRITE, {STACK_HI, sp_reg}, tgt[15:8]);
                                bundle.res[1] = mk_res(K_WRITE, {STACK_HI, sp_reg - 8'd1},
                                                       tgt[7:0]);
                                bundle.count = 3'd2;
                                sp_next = sp_reg - 8'd2;
                                pc_next = ea;
                                fin = 1'b1;
                            end
                            else
                                do_oper = 1'b1;
                        end
                        M_ABX, M_ABY:
                        begin
                            lo9 = {1'b0, oa_reg[7:0]} +
                                  {1'b0, (md_reg == M_ABX) ? x_reg : y_reg};
                            if (lo9[8] && dc_reg == 3'd4)
                                cyc_next = cyc_reg + 64'd1;
                            ea = {d, 8'h00} + {7'd0, lo9};
                            do_oper = 1'b1;
                        end
                        M_IND:
                        begin
                            oa_next = ea;
                            bundle.res[0] = mk_res(K_READ, ea, 8'h00);
                            bundle.count = 3'd1;
                            ph_next = PH_PTR_LO;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                PH_PTR_LO:
                begin
                    // pointer high byte wraps within the page
                    bundle.res[0] = mk_res(K_READ, {oa_reg[15:8], oa_reg[7:0] + 8'd1}, 8'h00);
                    bundle.count = 3'd1;
                    if (md_reg == M_IZY)
                    begin
                        lo9 = {1'b0, d} + {1'b0, y_reg};
                        if (lo9[8] && dc_reg == 3'd5)
                            cyc_next = cyc_reg + 64'd1;
                        oa_next = {7'd0, lo9};
                    end
                    else
                        oa_next = {8'h00, d};
                    ph_next = PH_PTR_HI;
                end
                PH_PTR_HI:
                begin
                    ea = {d, 8'h00} + oa_reg;
                    if (md_reg == M_IND)
                    begin
                        pc_next = ea;
                        fin = 1'b1;
                    end
                    else
                        do_oper = 1'b1;
                end
                PH_DATA:
                begin
                    fin = 1'b1;
                    case (op_reg)
                        OP_ORA: begin a_next = a_reg | d; p_next = nz(p_reg, a_next); end
                        OP_AND: begin a_next = a_reg & d; p_next = nz(p_reg, a_next); end
                        OP_EOR: begin a_next = a_reg ^ d; p_next = nz(p_reg, a_next); end
                        OP_ADC, OP_SBC:
                        begin
                            m = (op_reg == OP_SBC) ? ~d : d;
                            tot = {1'b0, a_reg} + {1'b0, m} + {8'd0, p_reg[0]};
                            p_next = p_reg;
                            p_next[0] = tot[8];
                            p_next[6] = (a_reg[7] ^ tot[7]) & (m[7] ^ tot[7]);
                            a_next = tot[7:0];
                            p_next = nz(p_next, a_next);
                        end
                        OP_CMP: p_next = cmp_flags(p_reg, a_reg, d);
                        OP_CPX: p_next = cmp_flags(p_reg, x_reg, d);
                        OP_CPY: p_next = cmp_flags(p_reg, y_reg, d);
                        OP_BIT:
                        begin
                            p_next = p_reg;
                            p_next[7] = d[7];
                            p_next[6] = d[6];
                            p_next[1] = ((d & a_reg) == 8'h00);
                        end
                        OP_LDA: begin a_next = d; p_next = nz(p_reg, d); end
                        OP_LDX: begin x_next = d; p_next = nz(p_reg, d); end
                        OP_LDY: begin y_next = d; p_next = nz(p_reg, d); end
                        OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC:
                        begin
                            mr = modify(op_reg, p_reg, d);
                            p_next = mr[15:8];
                            bundle.res[0] = mk_res(K_WRITE, oa_reg, mr[7:0]);
                            bundle.count = 3'd1;
                        end
                        default: p_next = p_reg;
                    endcase
                end
                PH_STK1:
                begin
                    case (op_reg)
                        OP_PLA:
                        begin
                            a_next = d;
                            p_next = nz(p_reg, d);
                            fin = 1'b1;
                        end
                        OP_RTI, OP_RTS:
                        begin
                            if (op_reg == OP_RTI)
                                p_next = d;
                            else
                                oa_next = {8'h00, d};
                            sp_next = sp_reg + 8'd1;
                            bundle.res[0] = mk_res(K_READ, {STACK_HI, sp_next}, 8'h00);
                            bundle.count = 3'd1;
                            ph_next = (op_reg == OP_RTI) ? PH_STK2 : PH_STK3;
                        end
                        default:
                        begin
                            p_next = d;
                            fin = 1'b1;
                        end
                    endcase
                end
                PH_STK2:
                begin
                    oa_next = {8'h00, d};
                    sp_next = sp_reg + 8'd1;
                    bundle.res[0] = mk_res(K_READ, {STACK_HI, sp_next}, 8'h00);
                    bundle.count = 3'd1;
                    ph_next = PH_STK3;
                end
                PH_STK3:
                begin
                    ea = {d, oa_reg[7:0]};
                    pc_next = (op_reg == OP_RTS) ? ea + 16'd1 : ea;
                    fin = 1'b1;
                end
                default: ph_next = ph_reg;
            endcase
        end

        // effective address known: store now or fetch the operand
        if (do_oper)
        begin
            if (op_reg == OP_STA || op_reg == OP_STX || op_reg == OP_STY)
            begin
                stv = (op_reg == OP_STA) ? a_reg : (op_reg == OP_STX) ? x_reg : y_reg;
                bundle.res[bundle.count[1:0]] = mk_res(K_WRITE, ea, stv);
                bundle.count = bundle.count + 3'd1;
                fin = 1'b1;
            end
            else
            begin
                oa_next = ea;
                bundle.res[bundle.count[1:0]] = mk_res(K_READ, ea, 8'h00);
                bundle.count = bundle.count + 3'd1;
                ph_next = PH_DATA;
            end
        end

        if (fin)
        begin
            bundle.res[bundle.count[1:0]] = mk_res(K_DONE, 16'h0000, 8'h00);
            bundle.count = bundle.count + 3'd1;
            ph_next = PH_IDLE;
        end

        for (int i = 0; i < MAX_RES; i++)
        begin
            if (bundle.res[i].kind == K_DONE || bundle.res[i].kind == K_BAD)
            begin
                bundle.res[i].prog_counter  = pc_next;
                bundle.res[i].accumulator   = a_next;
                bundle.res[i].index_x_out   = x_next;
                bundle.res[i].index_y_out   = y_next;
                bundle.res[i].stack_pointer = sp_next;
                bundle.res[i].status_flags  = p_next;
                bundle.res[i].cycle_count   = cyc_next;
            end
            if (bundle.count != 3'd0 && i[2:0] == bundle.count - 3'd1)
                bundle.res[i].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            pc_reg  <= '0;
            oa_reg  <= '0;
            a_reg   <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
            sp_reg  <= '0;
            p_reg   <= '0;
            cyc_reg <= '0;
            nmi_reg <= 1'b0;
            op_reg  <= OP_NOP;
            md_reg  <= M_IMP;
            dc_reg  <= '0;
        end
        else if (accept)
        begin
            ph_reg  <= ph_next;
            pc_reg  <= pc_next;
            oa_reg  <= oa_next;
            a_reg   <= a_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            sp_reg  <= sp_next;
            p_reg   <= p_next;
            cyc_reg <= cyc_next;
            nmi_reg <= nmi_next;
            op_reg  <= op_next;
            md_reg  <= md_next;
            dc_reg  <= dc_next;
        end
    end

endmodule

// ===== src/c65_outq.sv =====
// result register: holds a bundle of up to four results, sends one per unstalled cycle
module c65_outq
    import c65_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle,
    output logic    can_load,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    result_t    res_reg [MAX_RES];
    logic [2:0] cnt_reg;
    logic [2:0] idx_reg;
    logic       take;

    assign result_valid = (idx_reg < cnt_reg);
    assign take         = result_valid && !result_stall;
    // free once the last held result leaves this cycle
    assign can_load     = !result_valid || (take && idx_reg == cnt_reg - 3'd1);
    assign result       = res_reg[idx_reg[1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.count;
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RES; i++)
                res_reg[i] <= bundle.res[i];
        end
    end

endmodule

// ===== src/cpu_6502_instruction_core_unit.sv =====
// 6502 instruction core top level: step logic feeding the result register
//
// Bus-master 6502 core (documented opcodes, binary arithmetic). Each accepted item,
// a step start or the read data of the pending request, is worked by the step logic
// and leaves a bundle of one to four results in the result register, which sends
// them one per cycle unless the result side stalls. An item is taken every clock
// while each item yields one result and there is no stall; an item that yields more
// holds the result register until its last result leaves, and the next item is taken
// in that cycle. Read data that arrives with no step under way yields no result.
module cpu_6502_instruction_core_unit
    import c65_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    bundle_t bundle;
    logic    can_load;
    logic    accept;

    assign item_stall = !can_load;
    assign accept     = item_valid && can_load;

    c65_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .bundle (bundle)
    );

    c65_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .bundle       (bundle),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== src/c65_checker.sv =====
// port-level checks of the 6502 core and their binding to the top level
module c65_checker
    import c65_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // bus requests carry no register snapshot
    a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == K_READ || result.kind == K_WRITE)
        |-> result.cycle_count == 64'd0 && result.prog_counter == 16'd0)
        else $error("register fields set on a bus request");

    // a done or invalid-opcode result closes its item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == K_DONE || result.kind == K_BAD) |-> result.last)
        else $error("step end not marked last");

    // more results of the same item follow at once
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("gap inside a result group");

    // a new item enters only as the last held result leaves
    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && result_valid |-> result.last && !result_stall)
        else $error("item accepted while results still held");

endmodule

bind cpu_6502_instruction_core_unit c65_checker u_c65_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== dv/cpu_6502_checker.sv =====
// checker for the 6502 core: watches both channels, predicts results and compares them
`timescale 1ns / 1ps

module cpu_6502_checker
    import c65_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      outstanding
);

    typedef enum logic [3:0] {
        S_IDLE, S_VEC_LO, S_VEC_HI, S_OPCODE, S_OPLO, S_OPHI,
        S_PTRLO, S_PTRHI, S_DATA, S_STK1, S_STK2, S_STK3
    } seq_t;

    localparam logic [7:0] F_C = 8'h01;
    localparam logic [7:0] F_Z = 8'h02;
    localparam logic [7:0] F_I = 8'h04;
    localparam logic [7:0] F_D = 8'h08;
    localparam logic [7:0] F_V = 8'h40;
    localparam logic [7:0] F_N = 8'h80;

    logic [15:0] pc, oaddr;
    logic [7:0]  acc, xr, yr, sp, pf;
    logic [63:0] cycles;
    logic        nmi_latch;
    seq_t        phase;
    op_t         cur_op;
    mode_t       cur_mode;
    int          cur_cyc;

    result_t step_out[$];
    result_t expected_results[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic put(input kind_t k, input logic [15:0] a, input logic [7:0] d);
        result_t r;
        r = '0;
        r.kind = k;
        r.bus_address = a;
        r.write_data = d;
        if (k == K_DONE || k == K_BAD)
        begin
            r.prog_counter = pc;
            r.accumulator = acc;
            r.index_x_out = xr;
            r.index_y_out = yr;
            r.stack_pointer = sp;
            r.status_flags = pf;
            r.cycle_count = cycles;
        end
        step_out.push_back(r);
    endtask

    function automatic void set_f(input logic [7:0] f, input logic on);
        pf = on ? (pf | f) : (pf & ~f);
    endfunction

    function automatic void set_nz(input logic [7:0] v);
        set_f(F_N, v[7]);
        set_f(F_Z, v == 8'h00);
    endfunction

    task automatic done();
        put(K_DONE, 16'h0000, 8'h00);
        phase = S_IDLE;
    endtask

    task automatic req_read(input logic [15:0] a, input seq_t nxt);
        put(K_READ, a, 8'h00);
        phase = nxt;
    endtask

    task automatic push(input logic [7:0] b);
        put(K_WRITE, {STACK_HI, sp}, b);
        sp = sp - 8'd1;
    endtask

    task automatic pull(input seq_t nxt);
        sp = sp + 8'd1;
        req_read({STACK_HI, sp}, nxt);
    endtask

    task automatic fetch_vector(input logic [15:0] v);
        oaddr = v;
        req_read(v, S_VEC_LO);
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        set_f(F_N, diff[7]);
        set_f(F_C, r >= m);
        set_f(F_Z, r == m);
    endtask

    task automatic add_acc(input logic [7:0] m);
        logic [8:0] tot;
        tot = {1'b0, acc} + {1'b0, m} + {8'h00, pf[0]};
        set_f(F_C, tot[8]);
        set_f(F_V, ((acc ^ tot[7:0]) & (m ^ tot[7:0]) & 8'h80) != 8'h00);
        acc = tot[7:0];
        set_nz(acc);
    endtask

    task automatic alu_read(input logic [7:0] m);
        case (cur_op)
            OP_ORA: begin acc = acc | m; set_nz(acc); end
            OP_AND: begin acc = acc & m; set_nz(acc); end
            OP_EOR: begin acc = acc ^ m; set_nz(acc); end
            OP_ADC: add_acc(m);
            OP_SBC: add_acc(~m);
            OP_CMP: compare_reg(acc, m);
            OP_CPX: compare_reg(xr, m);
            OP_CPY: compare_reg(yr, m);
            OP_BIT:
            begin
                set_f(F_N, m[7]);
                set_f(F_V, m[6]);
                set_f(F_Z, (m & acc) == 8'h00);
            end
            OP_LDA: begin acc = m; set_nz(m); end
            OP_LDX: begin xr = m; set_nz(m); end
            OP_LDY: begin yr = m; set_nz(m); end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] shift_or_step(input logic [7:0] m);
        logic [7:0] r;
        logic cin;
        cin = pf[0];
        case (cur_op)
            OP_ASL: begin set_f(F_C, m[7]); r = {m[6:0], 1'b0}; end
            OP_LSR: begin set_f(F_C, m[0]); r = {1'b0, m[7:1]}; end
            OP_ROL: begin set_f(F_C, m[7]); r = {m[6:0], cin}; end
            OP_ROR: begin set_f(F_C, m[0]); r = {cin, m[7:1]}; end
            OP_INC: r = m + 8'd1;
            default: r = m - 8'd1;
        endcase
        set_nz(r);
        return r;
    endfunction

    task automatic implied_op();
        case (cur_op)
            OP_CLC: set_f(F_C, 1'b0);
            OP_SEC: set_f(F_C, 1'b1);
            OP_CLI: set_f(F_I, 1'b0);
            OP_SEI: set_f(F_I, 1'b1);
            OP_CLV: set_f(F_V, 1'b0);
            OP_CLD: set_f(F_D, 1'b0);
            OP_SED: set_f(F_D, 1'b1);
            OP_TAX: begin xr = acc; set_nz(xr); end
            OP_TXA: begin acc = xr; set_nz(acc); end
            OP_TAY: begin yr = acc; set_nz(yr); end
            OP_TYA: begin acc = yr; set_nz(acc); end
            OP_TSX: begin xr = sp; set_nz(xr); end
            OP_TXS: sp = xr;
            OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
            OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
            OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
            OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: acc = shift_or_step(acc);
            default: ;
        endcase
    endtask

    // opcode lookup by the aaabbbcc layout of the instruction set
    task automatic lookup(input logic [7:0] c, output logic ok, output op_t op,
                          output mode_t md, output int cy);
        logic [2:0] aaa, bbb;
        logic st;
        op_t g1[8];
        op_t g2[8];
        op_t fl[8];
        op_t sk[8];
        mode_t m1[8];
        int c1[8];
        g1 = '{OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC};
        g2 = '{OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_STX, OP_LDX, OP_DEC, OP_INC};
        fl = '{OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_TYA, OP_CLV, OP_CLD, OP_SED};
        sk = '{OP_PHP, OP_PLP, OP_PHA, OP_PLA, OP_DEY, OP_TAY, OP_INY, OP_INX};
        m1 = '{M_IZX, M_ZP, M_IMM, M_ABS, M_IZY, M_ZPX, M_ABY, M_ABX};
        c1 = '{6, 3, 2, 4, 5, 4, 4, 4};
        aaa = c[7:5];
        bbb = c[4:2];
        ok = 1'b1;
        op = OP_NOP;
        md = M_IMP;
        cy = 2;
        case (c[1:0])
            2'b01:
            begin
                op = g1[aaa];
                md = m1[bbb];
                cy = c1[bbb];
                if (op == OP_STA)
                begin
                    ok = (bbb != 3'd2);
                    if (bbb == 3'd4) cy = 6;
                    if (bbb == 3'd6 || bbb == 3'd7) cy = 5;
                end
            end
            2'b10:
            begin
                op = g2[aaa];
                st = (aaa == 3'd4 || aaa == 3'd5);
                case (bbb)
                    3'd0: begin ok = (aaa == 3'd5); md = M_IMM; end
                    3'd1: begin md = M_ZP; cy = st ? 3 : 5; end
                    3'd2:
                    begin
                        case (aaa)
                            3'd4: op = OP_TXA;
                            3'd5: op = OP_TAX;
                            3'd6: op = OP_DEX;
                            3'd7: op = OP_NOP;
                            default: ;
                        endcase
                    end
                    3'd3: begin md = M_ABS; cy = st ? 4 : 6; end
                    3'd5:
                    begin
                        md = st ? M_ZPY : M_ZPX;
                        cy = st ? 4 : 6;
                    end
                    3'd6:
                    begin
                        ok = st;
                        op = (aaa == 3'd4) ? OP_TXS : OP_TSX;
                    end
                    3'd7:
                    begin
                        ok = (aaa != 3'd4);
                        md = (aaa == 3'd5) ? M_ABY : M_ABX;
                        cy = (aaa == 3'd5) ? 4 : 7;
                    end
                    default: ok = 1'b0;
                endcase
            end
            2'b00:
            begin
                case (bbb)
                    3'd4: begin op = OP_BR; md = M_REL; end
                    3'd6: op = fl[aaa];
                    3'd2:
                    begin
                        op = sk[aaa];
                        if (aaa == 3'd0 || aaa == 3'd2) cy = 3;
                        if (aaa == 3'd1 || aaa == 3'd3) cy = 4;
                    end
                    3'd0:
                    begin
                        case (aaa)
                            3'd0: begin op = OP_BRK; cy = 7; end
                            3'd1: begin op = OP_JSR; md = M_ABS; cy = 6; end
                            3'd2: begin op = OP_RTI; cy = 6; end
                            3'd3: begin op = OP_RTS; cy = 6; end
                            3'd5: begin op = OP_LDY; md = M_IMM; end
                            3'd6: begin op = OP_CPY; md = M_IMM; end
                            3'd7: begin op = OP_CPX; md = M_IMM; end
                            default: ok = 1'b0;
                        endcase
                    end
                    3'd1:
                    begin
                        md = M_ZP;
                        cy = 3;
                        case (aaa)
                            3'd1: op = OP_BIT;
                            3'd4: op = OP_STY;
                            3'd5: op = OP_LDY;
                            3'd6: op = OP_CPY;
                            3'd7: op = OP_CPX;
                            default: ok = 1'b0;
                        endcase
                    end
                    3'd3:
                    begin
                        md = M_ABS;
                        cy = 4;
                        case (aaa)
                            3'd1: op = OP_BIT;
                            3'd2: begin op = OP_JMP; cy = 3; end
                            3'd3: begin op = OP_JMP; md = M_IND; cy = 5; end
                            3'd4: op = OP_STY;
                            3'd5: op = OP_LDY;
                            3'd6: op = OP_CPY;
                            3'd7: op = OP_CPX;
                            default: ok = 1'b0;
                        endcase
                    end
                    3'd5:
                    begin
                        md = M_ZPX;
                        cy = 4;
                        ok = (aaa == 3'd4 || aaa == 3'd5);
                        op = (aaa == 3'd4) ? OP_STY : OP_LDY;
                    end
                    default:
                    begin
                        ok = (aaa == 3'd5);
                        op = OP_LDY;
                        md = M_ABX;
                        cy = 4;
                    end
                endcase
            end
            default: ok = 1'b0;
        endcase
    endtask

    task automatic at_operand(input logic [15:0] ea);
        if (cur_op == OP_STA || cur_op == OP_STX || cur_op == OP_STY)
        begin
            put(K_WRITE, ea, cur_op == OP_STA ? acc : cur_op == OP_STX ? xr : yr);
            done();
        end
        else
        begin
            oaddr = ea;
            req_read(ea, S_DATA);
        end
    endtask

    task automatic decode_opcode(input logic [7:0] c);
        logic ok;
        logic [7:0] fsel;
        op_t op;
        mode_t md;
        int cy;
        lookup(c, ok, op, md, cy);
        if (!ok)
        begin
            put(K_BAD, pc - 16'd1, 8'h00);
            phase = S_IDLE;
            return;
        end
        cur_op = op;
        cur_mode = md;
        cur_cyc = cy;
        cycles = cycles + 64'(cy);
        case (md)
            M_IMP:
            begin
                case (op)
                    OP_BRK:
                    begin
                        pc = pc + 16'd1;
                        push(pc[15:8]);
                        push(pc[7:0]);
                        push(pf | FL_PUSHB);
                        set_f(F_I, 1'b1);
                        fetch_vector(VEC_IRQ);
                        return;
                    end
                    OP_PHA: push(acc);
                    OP_PHP: push(pf | FL_PUSHB);
                    OP_PLA, OP_PLP, OP_RTI, OP_RTS:
                    begin
                        pull(S_STK1);
                        return;
                    end
                    default: implied_op();
                endcase
                done();
            end
            M_IMM:
            begin
                oaddr = pc;
                req_read(pc, S_DATA);
                pc = pc + 16'd1;
            end
            M_REL:
            begin
                case (c[7:6])
                    2'd0: fsel = F_N;
                    2'd1: fsel = F_V;
                    2'd2: fsel = F_C;
                    default: fsel = F_Z;
                endcase
                if (((pf & fsel) != 8'h00) != c[5])
                begin
                    pc = pc + 16'd1;
                    done();
                end
                else
                begin
                    req_read(pc, S_OPLO);
                    pc = pc + 16'd1;
                end
            end
            default:
            begin
                req_read(pc, S_OPLO);
                pc = pc + 16'd1;
            end
        endcase
    endtask

    task automatic operand_low(input logic [7:0] d);
        logic [15:0] tgt;
        case (cur_mode)
            M_ZP:  at_operand({8'h00, d});
            M_ZPX: at_operand({8'h00, d + xr});
            M_ZPY: at_operand({8'h00, d + yr});
            M_IZX, M_IZY:
            begin
                oaddr = (cur_mode == M_IZX) ? {8'h00, d + xr} : {8'h00, d};
                req_read(oaddr, S_PTRLO);
            end
            M_REL:
            begin
                tgt = pc + {{8{d[7]}}, d};
                if (tgt[15:8] != pc[15:8]) cycles = cycles + 64'd1;
                cycles = cycles + 64'd1;
                pc = tgt;
                done();
            end
            default:
            begin
                oaddr = {8'h00, d};
                req_read(pc, S_OPHI);
                pc = pc + 16'd1;
            end
        endcase
    endtask

    task automatic operand_high(input logic [7:0] d);
        logic [15:0] ea, ret;
        logic [8:0] lo9;
        ea = {d, oaddr[7:0]};
        case (cur_mode)
            M_ABS:
            begin
                if (cur_op == OP_JMP)
                begin
                    pc = ea;
                    done();
                end
                else if (cur_op == OP_JSR)
                begin
                    ret = pc - 16'd1;
                    push(ret[15:8]);
                    push(ret[7:0]);
                    pc = ea;
                    done();
                end
                else at_operand(ea);
            end
            M_ABX, M_ABY:
            begin
                lo9 = {1'b0, oaddr[7:0]} + {1'b0, (cur_mode == M_ABX) ? xr : yr};
                if (lo9[8] && cur_cyc == 4) cycles = cycles + 64'd1;
                at_operand({d, 8'h00} + {7'h00, lo9});
            end
            M_IND:
            begin
                oaddr = ea;
                req_read(ea, S_PTRLO);
            end
            default: done();
        endcase
    endtask

    task automatic predict(input item_t it);
        logic [7:0] d;
        logic [15:0] ea;
        d = it.read_data;
        step_out.delete();
        if (!it.operation)
        begin
            if (it.nmi_request) nmi_latch = 1'b1;
            if (it.reset_line)
            begin
                cycles = '0;
                pf = FL_UNUSED;
                sp = SP_INIT;
                fetch_vector(VEC_RESET);
            end
            else if (nmi_latch || (!pf[2] && it.irq_line))
            begin
                push(pc[15:8]);
                push(pc[7:0]);
                push(pf | FL_UNUSED);
                cycles = cycles + 64'd7;
                if (nmi_latch)
                begin
                    nmi_latch = 1'b0;
                    fetch_vector(VEC_NMI);
                end
                else
                begin
                    set_f(F_I, 1'b1);
                    fetch_vector(VEC_IRQ);
                end
            end
            else
            begin
                req_read(pc, S_OPCODE);
                pc = pc + 16'd1;
            end
        end
        else
        begin
            case (phase)
                S_VEC_LO:
                begin
                    req_read(oaddr + 16'd1, S_VEC_HI);
                    oaddr = {8'h00, d};
                end
                S_VEC_HI:
                begin
                    pc = {d, oaddr[7:0]};
                    done();
                end
                S_OPCODE: decode_opcode(d);
                S_OPLO:   operand_low(d);
                S_OPHI:   operand_high(d);
                S_PTRLO:
                begin
                    // pointer high byte wraps within its page
                    req_read({oaddr[15:8], oaddr[7:0] + 8'd1}, S_PTRHI);
                    if (cur_mode == M_IZY)
                    begin
                        ea = {8'h00, d} + {8'h00, yr};
                        if (ea[8] && cur_cyc == 5) cycles = cycles + 64'd1;
                        oaddr = ea;
                    end
                    else oaddr = {8'h00, d};
                end
                S_PTRHI:
                begin
                    ea = {d, 8'h00} + oaddr;
                    if (cur_mode == M_IND)
                    begin
                        pc = ea;
                        done();
                    end
                    else at_operand(ea);
                end
                S_DATA:
                begin
                    if (cur_op <= OP_LDY) alu_read(d);
                    else if (cur_op >= OP_ASL && cur_op <= OP_DEC)
                        put(K_WRITE, oaddr, shift_or_step(d));
                    done();
                end
                S_STK1:
                begin
                    if (cur_op == OP_PLA)
                    begin
                        acc = d;
                        set_nz(d);
                        done();
                    end
                    else if (cur_op == OP_RTI)
                    begin
                        pf = d;
                        pull(S_STK2);
                    end
                    else if (cur_op == OP_RTS)
                    begin
                        oaddr = {8'h00, d};
                        pull(S_STK3);
                    end
                    else
                    begin
                        pf = d;
                        done();
                    end
                end
                S_STK2:
                begin
                    oaddr = {8'h00, d};
                    pull(S_STK3);
                end
                S_STK3:
                begin
                    ea = {d, oaddr[7:0]};
                    if (cur_op == OP_RTS) ea = ea + 16'd1;
                    pc = ea;
                    done();
                end
                default: ;
            endcase
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endtask

    task automatic check_result(input result_t got);
        result_t w;
        if (expected_results.size() == 0)
        begin
            report("result with nothing expected, kind", 64'(got.kind), 64'd0);
            return;
        end
        w = expected_results.pop_front();
        if (got.kind != w.kind)                   report("kind", got.kind, w.kind);
        if (got.bus_address != w.bus_address)     report("bus_address", got.bus_address,
                                                         w.bus_address);
        if (got.write_data != w.write_data)       report("write_data", got.write_data,
                                                         w.write_data);
        if (got.last != w.last)                   report("last", got.last, w.last);
        if (got.prog_counter != w.prog_counter)   report("prog_counter", got.prog_counter,
                                                         w.prog_counter);
        if (got.accumulator != w.accumulator)     report("accumulator", got.accumulator,
                                                         w.accumulator);
        if (got.index_x_out != w.index_x_out)     report("index_x_out", got.index_x_out,
                                                         w.index_x_out);
        if (got.index_y_out != w.index_y_out)     report("index_y_out", got.index_y_out,
                                                         w.index_y_out);
        if (got.stack_pointer != w.stack_pointer) report("stack_pointer", got.stack_pointer,
                                                         w.stack_pointer);
        if (got.status_flags != w.status_flags)   report("status_flags", got.status_flags,
                                                         w.status_flags);
        if (got.cycle_count != w.cycle_count)     report("cycle_count", got.cycle_count,
                                                         w.cycle_count);
    endtask

    initial
    begin
        errors = 0;
        outstanding = 0;
        pc = '0;
        oaddr = '0;
        acc = '0;
        xr = '0;
        yr = '0;
        sp = '0;
        pf = '0;
        cycles = '0;
        nmi_latch = 1'b0;
        phase = S_IDLE;
        cur_op = OP_NOP;
        cur_mode = M_IMP;
        cur_cyc = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall) predict(item);
            if (result_valid && !result_stall) check_result(result);
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for the 6502 core: memory-side stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb;
    import c65_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      errors;
    int      outstanding;

    int      n_last;
    kind_t   last_kind;
    int      n_items;
    logic [7:0] mem_bytes[$];

    cpu_6502_instruction_core_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    cpu_6502_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    // track the last result of each item so the memory side knows what to answer
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall && result.last)
        begin
            last_kind = result.kind;
            n_last = n_last + 1;
        end
    end

    // result-side stalls: runs of free flow and stall bursts, mostly short
    initial
    begin
        int run;
        int pick;
        result_stall = 1'b0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    result_stall = 1'b0;
                    run = $urandom_range(1, 20);
                end
                else if (pick < 95)
                begin
                    result_stall = 1'b1;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    result_stall = 1'b1;
                    run = $urandom_range(10, 25);
                end
            end
            run = run - 1;
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 30);
        repeat (gap) @(negedge clk);
        item_valid = 1'b1;
        item = it;
        do @(posedge clk); while (item_stall);
        n_items++;
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // one step: start it, then answer each read request with queued or random bytes;
    // reads_cut >= 0 abandons the step after that many answers
    task automatic run_step(input logic rst_l, input logic irq_l, input logic nmi_l,
                            input int reads_cut);
        item_t it;
        int mark;
        int reads;
        it = '0;
        it.reset_line = rst_l;
        it.irq_line = irq_l;
        it.nmi_request = nmi_l;
        it.read_data = 8'($urandom_range(0, 255));
        mark = n_last;
        send_item(it);
        reads = 0;
        forever
        begin
            while (n_last == mark) @(negedge clk);
            if (last_kind != K_READ || reads == reads_cut) break;
            it = '0;
            it.operation = 1'b1;
            it.read_data = (mem_bytes.size() > 0) ? mem_bytes.pop_front()
                                                  : 8'($urandom_range(0, 255));
            it.reset_line = 1'($urandom_range(0, 1));
            it.irq_line = 1'($urandom_range(0, 1));
            it.nmi_request = 1'($urandom_range(0, 1));
            mark = n_last;
            send_item(it);
            reads++;
        end
        mem_bytes.delete();
    endtask

    task automatic idle_read();
        item_t it;
        it = '0;
        it.operation = 1'b1;
        it.read_data = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic prog(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                        input logic [7:0] b3, input logic [7:0] b4, input int n);
        logic [7:0] bs[5];
        bs = '{b0, b1, b2, b3, b4};
        for (int i = 0; i < n; i++) mem_bytes.push_back(bs[i]);
        run_step(1'b0, 1'b0, 1'b0, -1);
    endtask

    initial
    begin
        int cut;
        n_last = 0;
        n_items = 0;
        last_kind = K_DONE;
        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        idle_read();
        mem_bytes = '{8'h00, 8'h80};
        run_step(1'b1, 1'b0, 1'b0, -1);
        prog(8'ha9, 8'h00, 0, 0, 0, 2);              // load zero
        prog(8'ha2, 8'hff, 0, 0, 0, 2);
        prog(8'h9a, 0, 0, 0, 0, 1);
        prog(8'ha9, 8'h7f, 0, 0, 0, 2);
        prog(8'h69, 8'h01, 0, 0, 0, 2);              // signed overflow
        prog(8'he9, 8'hff, 0, 0, 0, 2);
        prog(8'hb5, 8'hf0, 8'h55, 0, 0, 3);          // zero page index wraps
        prog(8'ha0, 8'hff, 0, 0, 0, 2);
        prog(8'hb1, 8'hff, 8'h80, 8'h12, 8'h77, 5);  // pointer wraps, page cross
        prog(8'hbd, 8'h80, 8'h20, 8'h11, 0, 4);
        prog(8'hd0, 8'h80, 0, 0, 0, 2);              // taken branch into another page
        prog(8'h6c, 8'hff, 8'h12, 8'h34, 8'h56, 5);  // indirect jump wraps in page
        prog(8'h20, 8'h00, 8'h30, 0, 0, 3);
        prog(8'h60, 8'h02, 8'h30, 0, 0, 3);
        prog(8'h06, 8'h10, 8'h81, 0, 0, 3);
        prog(8'hee, 8'h00, 8'h40, 8'hff, 0, 4);
        prog(8'h81, 8'h10, 8'h00, 8'h20, 0, 4);
        prog(8'h08, 0, 0, 0, 0, 1);
        prog(8'h28, 8'hff, 0, 0, 0, 2);
        prog(8'h24, 8'h10, 8'hc0, 0, 0, 3);
        prog(8'h02, 0, 0, 0, 0, 1);                  // invalid opcode
        prog(8'h00, 8'h00, 8'h90, 0, 0, 3);
        prog(8'h40, 8'he3, 8'h00, 8'h80, 0, 4);
        prog(8'h58, 0, 0, 0, 0, 1);
        mem_bytes = '{8'h00, 8'ha0};
        run_step(1'b0, 1'b1, 1'b0, -1);
        mem_bytes = '{8'h00, 8'hb0};
        run_step(1'b0, 1'b0, 1'b1, -1);
        mem_bytes = '{8'had, 8'h00};
        run_step(1'b0, 1'b0, 1'b0, 2);               // abandoned mid step
        idle_read();

        // hold off until the core has drained everything
        while (outstanding != 0) @(negedge clk);

        // random part
        while (n_items < 260)
        begin
            cut = ($urandom_range(0, 99) < 4) ? $urandom_range(0, 3) : -1;
            run_step($urandom_range(0, 99) < 5, $urandom_range(0, 99) < 30,
                     $urandom_range(0, 99) < 5, cut);
            if ($urandom_range(0, 99) < 4) idle_read();
        end

        while (outstanding != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
